FILE: src/uv_sphere_mesh_generator_defines.svh
// Assertion macros for the sphere mesh generator modules; usmg_out uses them.
`ifndef UV_SPHERE_MESH_GENERATOR_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define USMG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion %m failed");
// Next-cycle implication, disabled while reset is high.
`define USMG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion %m failed");
`else
`define USMG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define USMG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/usmg_pkg.sv
package usmg_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_STACKS = 2'd2;

  // Command codes carried in the input word's tuser.
  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_CELL = 1'b1;

  localparam int IDX_W = 11;
  localparam int CORNER_W = 21;
  localparam int DIV_QUO_W = 33;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 200;

  // CORDIC start vector: the inverse gain in Q2.30.
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Items that ride along the pipeline next to the arithmetic.
  typedef struct packed {
    logic                cmd;
    logic                first;
    logic                second;
    logic [CORNER_W-1:0] k1;
    logic [CORNER_W-1:0] k2;
    logic [15:0]         tex_u;
    logic [15:0]         tex_v;
  } usmg_side_t;

  // Vertex arithmetic results at the end of the pipeline.
  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } usmg_vert_t;

  // Arctangent of 2^-k as a fraction of a turn (2^32 = one turn).
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] r;
    case (k)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Saturate a wide value into the Q1.14 range of a unit normal.
  function automatic logic signed [15:0] sat_q14(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) begin
      r = 16'sd16384;
    end else if (v < -64'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

FILE: src/usmg_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// The divisor must hold still while words are in flight.
module usmg_div #(
  parameter int DEN_W = 11,
  parameter int QUO_W = 33
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  logic [DEN_W-1:0] rem_q [1:QUO_W];
  logic [QUO_W-1:0] lq_q [1:QUO_W];

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_prev;
    logic [QUO_W-1:0] lq_prev;
    logic [DEN_W:0]   trial;

    // The top bits of the dividend are known to be below the divisor.
    if (k == 1) begin : g_first
      assign rem_prev = num[DEN_W+QUO_W-1:QUO_W];
      assign lq_prev = num[QUO_W-1:0];
    end else begin : g_rest
      assign rem_prev = rem_q[k-1];
      assign lq_prev = lq_q[k-1];
    end

    assign trial = {rem_prev, lq_prev[QUO_W-1]};

    // Shift in one dividend bit, subtract when it fits.
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den}) begin
          rem_q[k] <= DEN_W'(trial - {1'b0, den});
          lq_q[k] <= {lq_prev[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[DEN_W-1:0];
          lq_q[k] <= {lq_prev[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = lq_q[QUO_W];

endmodule

FILE: src/usmg_cordic.sv
// Pipelined CORDIC in rotation mode: one micro-rotation per stage, then
// a register that maps the quadrant.
module usmg_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_v,
  output logic signed [31:0] sin_v
);
  import usmg_pkg::*;

  logic signed [31:0] x_q [1:STEPS];
  logic signed [31:0] y_q [1:STEPS];
  logic signed [31:0] z_q [1:STEPS];
  logic [1:0]         quad_q [1:STEPS];

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic signed [31:0] x_prev;
    logic signed [31:0] y_prev;
    logic signed [31:0] z_prev;
    logic [1:0]         quad_prev;
    logic signed [31:0] atan_k;

    if (k == 1) begin : g_first
      assign x_prev = CORDIC_GAIN;
      assign y_prev = '0;
      assign z_prev = $signed({2'b00, phase[29:0]});
      assign quad_prev = phase[31:30];
    end else begin : g_rest
      assign x_prev = x_q[k-1];
      assign y_prev = y_q[k-1];
      assign z_prev = z_q[k-1];
      assign quad_prev = quad_q[k-1];
    end

    assign atan_k = $signed(atan_turn(k - 1));

    // Rotate toward zero residual angle; shifts floor.
    always_ff @(posedge clk) begin
      if (en) begin
        quad_q[k] <= quad_prev;
        if (!z_prev[31]) begin
          x_q[k] <= x_prev - (y_prev >>> (k - 1));
          y_q[k] <= y_prev + (x_prev >>> (k - 1));
          z_q[k] <= z_prev - atan_k;
        end else begin
          x_q[k] <= x_prev + (y_prev >>> (k - 1));
          y_q[k] <= y_prev - (x_prev >>> (k - 1));
          z_q[k] <= z_prev + atan_k;
        end
      end
    end
  end

  // Quadrant from the top two phase bits.
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_q[STEPS])
        2'd0: begin
          cos_v <= x_q[STEPS];
          sin_v <= y_q[STEPS];
        end
        2'd1: begin
          cos_v <= -y_q[STEPS];
          sin_v <= x_q[STEPS];
        end
        2'd2: begin
          cos_v <= -x_q[STEPS];
          sin_v <= -y_q[STEPS];
        end
        default: begin
          cos_v <= y_q[STEPS];
          sin_v <= -x_q[STEPS];
        end
      endcase
    end
  end

endmodule

FILE: src/usmg_out.sv
`include "uv_sphere_mesh_generator_defines.svh"

// Output register. A vertex gives one word; a cell gives one or two
// triangle words, and the pipeline holds while the first one goes out.
module usmg_out (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  usmg_pkg::usmg_side_t                  side,
  input  usmg_pkg::usmg_vert_t                  vert,
  output logic                                  en,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic                                  m_axis_tlast,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
  // corner_a, corner_b, corner_c, zero pad
  output logic [usmg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import usmg_pkg::*;

  logic o_free;
  logic two;
  logic take;
  logic pend;
  logic pend_next;
  logic [CORNER_W-1:0] ca;
  logic [CORNER_W-1:0] cb;
  logic [CORNER_W-1:0] cc;
  logic fin;
  logic [OUT_TDATA_W-1:0] word;

  assign o_free = !m_axis_tvalid || m_axis_tready;
  assign two = (side.cmd == CMD_CELL) && side.first && side.second;
  assign take = in_valid && o_free;
  assign en = !in_valid || (o_free && (!two || pend));

  // Pick the triangle that goes out now.
  always_comb begin
    if (side.first && !pend) begin
      ca = side.k1;
      cb = side.k2;
      cc = side.k1 + CORNER_W'(1);
      fin = !side.second;
    end else begin
      ca = side.k1 + CORNER_W'(1);
      cb = side.k2;
      cc = side.k2 + CORNER_W'(1);
      fin = 1'b1;
    end
  end

  // Pack the result word; unused fields are zero.
  always_comb begin
    word = '0;
    if (side.cmd == CMD_VERTEX) begin
      word[16:0] = vert.pos_x;
      word[33:17] = vert.pos_y;
      word[50:34] = vert.pos_z;
      word[66:51] = side.tex_u;
      word[82:67] = side.tex_v;
      word[98:83] = vert.norm_x;
      word[114:99] = vert.norm_y;
      word[130:115] = vert.norm_z;
    end else begin
      word[151:131] = ca;
      word[172:152] = cb;
      word[193:173] = cc;
    end
  end

  always_comb begin
    pend_next = pend;
    if (take) begin
      pend_next = two && !pend;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= pend_next;
      if (take) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= word;
      m_axis_tlast <= (side.cmd == CMD_VERTEX) ? 1'b1 : fin;
    end
  end

  `USMG_ASSERT_IMPL(a_pend_cell, clk, rst, pend, in_valid && side.cmd == CMD_CELL)
  `USMG_ASSERT_NEXT(a_take_shows, clk, rst, take, m_axis_tvalid)
  `USMG_ASSERT_IMPL(a_two_waits, clk, rst, in_valid && en && two, pend)
  `USMG_ASSERT_NEXT(a_first_then_second, clk, rst, take && two && !pend, pend)

endmodule

FILE: src/uv_sphere_mesh_generator.sv
// UV sphere mesh generator.
// Input words arrive on s_axis: tuser is the command (vertex or cell),
// tdata carries the stack index in bits 10:0 and the sector index in
// bits 21:11. Result words leave on m_axis; tlast marks the last word
// caused by one input word. A vertex gives one word, a cell one or two
// triangle words, and an index out of range gives none.
// Radius, sector count and stack count are written on the cfg channel
// (index 0, 1, 2); the user must write them only while no word is in
// flight, as the block does not enforce it. cfg_ready is always high.
// A result word passes the input register, the 33-stage quotient
// pipeline, the phase register, the CORDIC pipeline, the normal and
// position registers and the output register on its way to m_axis.
// One input word is taken per cycle while the pipeline does not hold;
// a two-triangle cell holds it while its first triangle word goes out.
// Else the pipeline holds, and s_axis_tready drops, only once a word
// waits in the last stage behind a full output register. Reset clears
// all valid bits and loads radius 1.0, 36 sectors and 18 stacks.
module uv_sphere_mesh_generator #(
  parameter int MAX_DIVISIONS = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // command
  input  logic                                  s_axis_tuser,
  // stack_index, sector_index, zero pad
  input  logic [usmg_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic                                  m_axis_tlast,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
  // corner_a, corner_b, corner_c, zero pad
  output logic [usmg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);
  import usmg_pkg::*;

  localparam int DIV_STAGE = DIV_QUO_W;
  localparam int TEX_STAGE = DIV_STAGE + 1;
  localparam int LAST = DIV_STAGE + CORDIC_STEPS + 6;
  localparam int NUM_W = IDX_W + DIV_QUO_W;

  logic en;
  logic [15:0] radius;
  logic [IDX_W-1:0] sector_count;
  logic [IDX_W-1:0] stack_count;
  logic [IDX_W-1:0] s_cl;
  logic [IDX_W-1:0] t_cl;
  logic [IDX_W-1:0] in_i;
  logic [IDX_W-1:0] in_j;
  logic in_range;
  logic [23:0] k1_full;

  logic vld [0:LAST];
  usmg_side_t side [0:LAST];

  logic [NUM_W-1:0] num_sp;
  logic [NUM_W-1:0] num_tp;
  logic [NUM_W-1:0] num_tu;
  logic [NUM_W-1:0] num_tv;
  logic [DIV_QUO_W-1:0] q_sp;
  logic [DIV_QUO_W-1:0] q_tp;
  logic [DIV_QUO_W-1:0] q_tu;
  logic [DIV_QUO_W-1:0] q_tv;
  logic [31:0] phase_sp;
  logic [31:0] phase_tp;

  logic signed [31:0] cos_a;
  logic signed [31:0] sin_a;
  logic signed [31:0] cos_b;
  logic signed [31:0] sin_b;
  logic signed [31:0] ny_raw;
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_z;
  logic signed [15:0] ny_m;
  logic signed [15:0] nx_n;
  logic signed [15:0] ny_n;
  logic signed [15:0] nz_n;
  logic signed [32:0] rp_x;
  logic signed [32:0] rp_y;
  logic signed [32:0] rp_z;
  logic signed [15:0] nx_p;
  logic signed [15:0] ny_p;
  logic signed [15:0] nz_p;
  usmg_vert_t vert;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      sector_count <= 11'd36;
      stack_count <= 11'd18;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS: radius <= cfg_data;
        REG_SECTORS: sector_count <= cfg_data[IDX_W-1:0];
        REG_STACKS: stack_count <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Division counts saturated into their legal ranges.
  always_comb begin
    if (sector_count < 11'd3) begin
      s_cl = 11'd3;
    end else if (32'(sector_count) > MAX_DIVISIONS) begin
      s_cl = IDX_W'(MAX_DIVISIONS);
    end else begin
      s_cl = sector_count;
    end
    if (stack_count < 11'd2) begin
      t_cl = 11'd2;
    end else if (32'(stack_count) > MAX_DIVISIONS) begin
      t_cl = IDX_W'(MAX_DIVISIONS);
    end else begin
      t_cl = stack_count;
    end
  end

  // Input stage: range check, corner indexes and dividends.
  assign in_i = s_axis_tdata[10:0];
  assign in_j = s_axis_tdata[21:11];
  assign s_axis_tready = en;
  assign in_range = (s_axis_tuser == CMD_VERTEX) ? (in_i <= t_cl && in_j <= s_cl)
                                                 : (in_i < t_cl && in_j < s_cl);
  assign k1_full = 24'(in_i) * 24'({1'b0, s_cl} + 12'd1) + 24'(in_j);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].cmd <= s_axis_tuser;
      side[0].first <= (in_i != '0);
      side[0].second <= (in_i != t_cl - 11'd1);
      side[0].k1 <= CORNER_W'(k1_full);
      side[0].k2 <= CORNER_W'(k1_full + 24'(s_cl) + 24'd1);
      side[0].tex_u <= '0;
      side[0].tex_v <= '0;
      num_sp <= {1'b0, in_j, 32'd0} + NUM_W'(s_cl >> 1);
      num_tp <= {2'b00, in_i, 31'd0} + NUM_W'(t_cl >> 1);
      num_tu <= {18'd0, 11'(s_cl - in_j), 15'd0} + NUM_W'(s_cl >> 1);
      num_tv <= {18'd0, 11'(t_cl - in_i), 15'd0} + NUM_W'(t_cl >> 1);
    end
  end

  // Side items follow the arithmetic; texture values join after division.
  for (genvar k = 1; k <= LAST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    if (k == TEX_STAGE) begin : g_tex
      usmg_side_t side_tex;

      always_comb begin
        side_tex = side[k-1];
        side_tex.tex_u = q_tu[15:0];
        side_tex.tex_v = q_tv[15:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= side_tex;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // Angle and texture quotients.
  usmg_div #(.DEN_W(IDX_W), .QUO_W(DIV_QUO_W)) u_div_sp (
    .clk(clk), .en(en), .num(num_sp), .den(s_cl), .quo(q_sp)
  );
  usmg_div #(.DEN_W(IDX_W), .QUO_W(DIV_QUO_W)) u_div_tp (
    .clk(clk), .en(en), .num(num_tp), .den(t_cl), .quo(q_tp)
  );
  usmg_div #(.DEN_W(IDX_W), .QUO_W(DIV_QUO_W)) u_div_tu (
    .clk(clk), .en(en), .num(num_tu), .den(s_cl), .quo(q_tu)
  );
  usmg_div #(.DEN_W(IDX_W), .QUO_W(DIV_QUO_W)) u_div_tv (
    .clk(clk), .en(en), .num(num_tv), .den(t_cl), .quo(q_tv)
  );

  // Phases in turns; the stack angle counts down from a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      phase_sp <= q_sp[31:0];
      phase_tp <= 32'h4000_0000 - q_tp[31:0];
    end
  end

  usmg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
    .clk(clk), .en(en), .phase(phase_tp), .cos_v(cos_a), .sin_v(sin_a)
  );
  usmg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
    .clk(clk), .en(en), .phase(phase_sp), .cos_v(cos_b), .sin_v(sin_b)
  );

  // Normal products, and the y normal straight from the stack sine.
  assign ny_raw = (sin_a + 32'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= 64'(cos_a) * 64'(cos_b);
      prod_z <= 64'(cos_a) * 64'(sin_b);
      ny_m <= sat_q14(64'(ny_raw));
    end
  end

  // Round the products back to Q1.14.
  always_ff @(posedge clk) begin
    if (en) begin
      nx_n <= sat_q14((prod_x + 64'sh2000_0000_0000) >>> 46);
      nz_n <= sat_q14((prod_z + 64'sh2000_0000_0000) >>> 46);
      ny_n <= ny_m;
    end
  end

  // Scale by the radius.
  always_ff @(posedge clk) begin
    if (en) begin
      rp_x <= $signed({1'b0, radius}) * nx_n;
      rp_y <= $signed({1'b0, radius}) * ny_n;
      rp_z <= $signed({1'b0, radius}) * nz_n;
      nx_p <= nx_n;
      ny_p <= ny_n;
      nz_p <= nz_n;
    end
  end

  // Round the positions to Q8.8.
  always_ff @(posedge clk) begin
    if (en) begin
      vert.pos_x <= 17'((rp_x + 33'sd8192) >>> 14);
      vert.pos_y <= 17'((rp_y + 33'sd8192) >>> 14);
      vert.pos_z <= 17'((rp_z + 33'sd8192) >>> 14);
      vert.norm_x <= nx_p;
      vert.norm_y <= ny_p;
      vert.norm_z <= nz_p;
    end
  end

  usmg_out u_out (
    .clk(clk),
    .rst(rst),
    .in_valid(vld[LAST]),
    .side(side[LAST]),
    .vert(vert),
    .en(en),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tdata(m_axis_tdata)
  );

endmodule
